### rtl/fdlm_pkg.sv
// Shared types and constants of the fault debounce and latch manager.
`timescale 1ns / 1ps
package fdlm_pkg;

  localparam int unsigned NUM_LANES = 6;
  localparam int unsigned NUM_CFG   = 4;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned RAW_W     = 6;
  localparam int unsigned SOFT_W    = 5;
  localparam int unsigned DH_W      = 6;
  localparam int unsigned MASK_A_W  = 8;
  localparam int unsigned MASK_B_W  = 4;
  localparam int unsigned HARD_W    = MASK_A_W + MASK_B_W;
  localparam int unsigned CODE_W    = 4;

  typedef logic [1:0] reg_sel_t;

  localparam reg_sel_t REG_LEAK   = 2'd0;
  localparam reg_sel_t REG_DRIVER = 2'd1;
  localparam reg_sel_t REG_STALL  = 2'd2;
  localparam reg_sel_t REG_TEMP   = 2'd3;

  // confirm register used by each debounce lane
  localparam reg_sel_t LANE_REG [NUM_LANES] = '{
    REG_LEAK, REG_DRIVER, REG_DRIVER, REG_STALL, REG_STALL, REG_TEMP
  };

  // range sensor reports "valid"; the soft bit means "invalid"
  localparam logic [SOFT_W-1:0] SOFT_INVERT = 5'b00010;

  localparam logic [CODE_W-1:0] CODE_NONE = '0;

  typedef struct packed {
    logic                hard_fault_active;
    logic                soft_fault_active;
    logic [MASK_A_W-1:0] hard_mask_a;
    logic [MASK_B_W-1:0] hard_mask_b;
    logic [SOFT_W-1:0]   soft_mask;
    logic [CODE_W-1:0]   first_fault_code;
  } result_t;

endpackage

### rtl/fdlm_ifs.sv
// Handshake channel interfaces: input word, result word and config write.
`timescale 1ns / 1ps
interface fdlm_in_if;
  logic                          valid;
  logic                          ready;
  logic [fdlm_pkg::DT_W-1:0]     elapsed_ticks;
  logic [fdlm_pkg::RAW_W-1:0]    debounce_raw;
  logic [fdlm_pkg::SOFT_W-1:0]   soft_conditions;
  logic [fdlm_pkg::DH_W-1:0]     direct_hard;

  modport source (output valid, elapsed_ticks, debounce_raw, soft_conditions, direct_hard,
                  input ready);
  modport sink (input valid, elapsed_ticks, debounce_raw, soft_conditions, direct_hard,
                output ready);
endinterface

interface fdlm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hard_fault_active;
  logic                          soft_fault_active;
  logic [fdlm_pkg::MASK_A_W-1:0] hard_mask_a;
  logic [fdlm_pkg::MASK_B_W-1:0] hard_mask_b;
  logic [fdlm_pkg::SOFT_W-1:0]   soft_mask;
  logic [fdlm_pkg::CODE_W-1:0]   first_fault_code;

  modport source (output valid, hard_fault_active, soft_fault_active, hard_mask_a,
                  hard_mask_b, soft_mask, first_fault_code, input ready);
  modport sink (input valid, hard_fault_active, soft_fault_active, hard_mask_a,
                hard_mask_b, soft_mask, first_fault_code, output ready);
endinterface

interface fdlm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fdlm_pkg::CFG_IDX_W-1:0] index;
  logic [fdlm_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/fdlm_lane.sv
// One debounce lane: persistence timer with saturating add and confirm compare.
`timescale 1ns / 1ps
module fdlm_lane #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic                        raw_i,
  input  logic [fdlm_pkg::CFG_W-1:0]  confirm_i,
  input  logic [fdlm_pkg::DT_W-1:0]   dt_i,
  output logic                        hit_o
);
  import fdlm_pkg::*;

  localparam int unsigned SUM_W = ((TIMER_WIDTH > DT_W) ? TIMER_WIDTH : DT_W) + 1;
  localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic [SUM_W-1:0]       sum;
  logic                   sat;
  logic [TIMER_WIDTH-1:0] t_new;
  logic                   instant;

  assign sum     = SUM_W'(timer_q) + SUM_W'(dt_i);
  assign sat     = |sum[SUM_W-1:TIMER_WIDTH];
  assign t_new   = sat ? '1 : sum[TIMER_WIDTH-1:0];
  assign instant = (confirm_i == '0);

  assign hit_o = raw_i & (instant | (CMP_W'(t_new) >= CMP_W'(confirm_i)));

  always_comb begin
    timer_d = timer_q;
    if (upd_i) begin
      if (!raw_i) begin
        timer_d = '0;
      end else if (!instant) begin
        timer_d = t_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
    end else begin
      timer_q <= timer_d;
    end
  end

endmodule

### rtl/fdlm_merge.sv
// Merge stage: maps lane hits and direct faults onto sticky masks, latch and first code.
`timescale 1ns / 1ps
module fdlm_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            upd_i,
  input  logic [fdlm_pkg::NUM_LANES-1:0]  hit_i,
  input  logic [fdlm_pkg::SOFT_W-1:0]     soft_i,
  input  logic [fdlm_pkg::DH_W-1:0]       dh_i,
  output fdlm_pkg::result_t               res_o
);
  import fdlm_pkg::*;

  logic                latched_q, latched_d;
  logic [MASK_A_W-1:0] mask_a_q, mask_a_d;
  logic [MASK_B_W-1:0] mask_b_q, mask_b_d;
  logic [SOFT_W-1:0]   soft_q, soft_d;
  logic [CODE_W-1:0]   code_q, code_d;

  logic [MASK_A_W-1:0] a;
  logic [MASK_B_W-1:0] b;
  logic [HARD_W-1:0]   all_hard;
  logic [CODE_W-1:0]   prio_code;

  assign a = {dh_i[3], hit_i[5], dh_i[2], dh_i[1], dh_i[0], hit_i[2], hit_i[1], hit_i[0]};
  assign b = {hit_i[4], hit_i[3], dh_i[5], dh_i[4]};
  assign all_hard = {b, a};

  always_comb begin
    prio_code = CODE_NONE;
    for (int k = HARD_W - 1; k >= 0; k--) begin
      if (all_hard[k]) begin
        prio_code = CODE_W'(k + 1);
      end
    end
  end

  always_comb begin
    latched_d = latched_q;
    mask_a_d  = mask_a_q;
    mask_b_d  = mask_b_q;
    soft_d    = soft_q;
    code_d    = code_q;
    if (upd_i) begin
      soft_d = soft_i ^ SOFT_INVERT;
      if (|all_hard) begin
        if (code_q == CODE_NONE && !latched_q) begin
          code_d = prio_code;
        end
        latched_d = 1'b1;
        mask_a_d  = mask_a_q | a;
        mask_b_d  = mask_b_q | b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= 1'b0;
      mask_a_q  <= '0;
      mask_b_q  <= '0;
      soft_q    <= '0;
      code_q    <= CODE_NONE;
    end else begin
      latched_q <= latched_d;
      mask_a_q  <= mask_a_d;
      mask_b_q  <= mask_b_d;
      soft_q    <= soft_d;
      code_q    <= code_d;
    end
  end

  assign res_o.hard_fault_active = latched_d;
  assign res_o.soft_fault_active = |soft_d;
  assign res_o.hard_mask_a       = mask_a_d;
  assign res_o.hard_mask_b       = mask_b_d;
  assign res_o.soft_mask         = soft_d;
  assign res_o.first_fault_code  = code_d;

  a_latch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_q |=> latched_q)
    else $error("hard fault latch cleared");

  a_code_needs_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_q != CODE_NONE) |-> latched_q)
    else $error("first code set without latch");

  a_masks_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (((mask_a_q & $past(mask_a_q)) == $past(mask_a_q)) &&
              ((mask_b_q & $past(mask_b_q)) == $past(mask_b_q))))
    else $error("sticky mask bit cleared");

  a_query_holds_soft: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(soft_q) && $stable(code_q))
    else $error("state changed without update");

endmodule

### rtl/fault_debounce_latch_manager.sv
// Top level of the fault debounce and latch manager.
`timescale 1ns / 1ps
// One result word per input word. Six debounce lanes and the merge stage settle an
// input word in the cycle it is accepted, and its result sits in a two-word output
// buffer from the next cycle on; a new word is taken every cycle while the buffer
// has room. in_i.ready drops only while the buffer holds two unread results. A word with
// zero elapsed ticks changes no state and returns the current status. Config writes
// are taken on any cycle; indexes beyond the four confirm registers are ignored.
module fault_debounce_latch_manager #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fdlm_in_if.sink   in_i,
  fdlm_cfg_if.sink  cfg_i,
  fdlm_out_if.source out_o
);
  import fdlm_pkg::*;

  logic [CFG_W-1:0]     confirm_q [NUM_CFG];
  logic                 in_acc;
  logic                 upd;
  logic [NUM_LANES-1:0] hit;
  result_t              res;

  result_t              buf0_q, buf0_d, buf1_q, buf1_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        confirm_q[i] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(NUM_CFG))) begin
      confirm_q[cfg_i.index[1:0]] <= cfg_i.data;
    end
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign in_acc     = in_i.valid & in_i.ready;
  assign upd        = in_acc & (in_i.elapsed_ticks != '0);

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    fdlm_lane #(
      .TIMER_WIDTH (TIMER_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .upd_i     (upd),
      .raw_i     (in_i.debounce_raw[k]),
      .confirm_i (confirm_q[LANE_REG[k]]),
      .dt_i      (in_i.elapsed_ticks),
      .hit_o     (hit[k])
    );
  end

  fdlm_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .hit_i  (hit),
    .soft_i (in_i.soft_conditions),
    .dh_i   (in_i.direct_hard),
    .res_o  (res)
  );

  // two-word output buffer, buf0 is the head
  assign pop = out_o.valid & out_o.ready;

  always_comb begin
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    cnt_d  = cnt_q;
    if (in_acc && !pop) begin
      if (cnt_q == 2'd0) begin
        buf0_d = res;
      end else begin
        buf1_d = res;
      end
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !in_acc) begin
      buf0_d = buf1_q;
      cnt_d  = cnt_q - 2'd1;
    end else if (pop && in_acc) begin
      if (cnt_q == 2'd1) begin
        buf0_d = res;
      end else begin
        buf0_d = buf1_q;
        buf1_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

  assign out_o.valid             = (cnt_q != 2'd0);
  assign out_o.hard_fault_active = buf0_q.hard_fault_active;
  assign out_o.soft_fault_active = buf0_q.soft_fault_active;
  assign out_o.hard_mask_a       = buf0_q.hard_mask_a;
  assign out_o.hard_mask_b       = buf0_q.hard_mask_b;
  assign out_o.soft_mask         = buf0_q.soft_mask;
  assign out_o.first_fault_code  = buf0_q.first_fault_code;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer overfilled");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("output buffer lost a word");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full output buffer drained without a read");

endmodule

### tb/tb_top.sv
// Self-checking bench for the fault debounce and latch manager: random words, status prediction.
`timescale 1ns / 1ps
module tb_top;
  import fdlm_pkg::*;

  localparam int unsigned TICK_W = 24;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [CFG_W-1:0] CONFIRM_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = CFG_IDX_W'(NUM_CFG);
  localparam logic [CFG_IDX_W-1:0] IDX_TOP = '1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS = 200;
  localparam int MAX_WAIT = 13;

  typedef enum logic [1:0] {DT_LONG, DT_SHORT, DT_ANY} dt_mode_e;

  typedef struct packed {
    logic [DT_W-1:0]   elapsed;
    logic [RAW_W-1:0]  raw;
    logic [SOFT_W-1:0] soft_cond;
    logic [DH_W-1:0]   hard;
  } fault_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fdlm_in_if  in_bus ();
  fdlm_out_if out_bus ();
  fdlm_cfg_if cfg_bus ();

  fault_debounce_latch_manager #(
    .TIMER_WIDTH(TICK_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .cfg_i (cfg_bus),
    .out_o (out_bus)
  );

  // predicted block state
  logic [CFG_W-1:0]    confirm_ticks [NUM_CFG];
  logic [TICK_W-1:0]   lane_timer [NUM_LANES];
  logic                hard_latch;
  logic [MASK_A_W-1:0] sticky_a;
  logic [MASK_B_W-1:0] sticky_b;
  logic [SOFT_W-1:0]   soft_now;
  logic [CODE_W-1:0]   first_code;

  fault_word_t pending_words [$];
  result_t     status_q [$];
  fault_word_t driven_word;
  fault_word_t next_word;

  int  in_gap;
  int  out_stall;
  int  idle_cycles;
  int  mismatch_count;
  bit  steady_in;
  bit  steady_out;

  // random stream state
  logic [RAW_W-1:0] lane_raw;
  int               run_left [NUM_LANES];
  int               seg_left;
  dt_mode_e         dt_mode;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic result_t step_status(fault_word_t w);
    logic [NUM_LANES-1:0] hit;
    logic [TICK_W:0]      sum;
    logic [CFG_W-1:0]     need;
    logic [MASK_A_W-1:0]  a;
    logic [MASK_B_W-1:0]  b;
    logic [HARD_W-1:0]    all_hard;
    result_t              r;
    hit = '0;
    if (w.elapsed != '0) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        need = confirm_ticks[LANE_REG[k]];
        if (!w.raw[k]) begin
          lane_timer[k] = '0;
        end else if (need == '0) begin
          hit[k] = 1'b1;
        end else begin
          sum = lane_timer[k] + w.elapsed;
          lane_timer[k] = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
          hit[k] = (lane_timer[k] >= need);
        end
      end
      soft_now = w.soft_cond ^ SOFT_INVERT;
      a = {w.hard[3], hit[5], w.hard[2:0], hit[2:0]};
      b = {hit[4:3], w.hard[5:4]};
      all_hard = {b, a};
      if (all_hard != '0) begin
        if (first_code == CODE_NONE && !hard_latch) begin
          for (int k = HARD_W - 1; k >= 0; k--) begin
            if (all_hard[k]) first_code = CODE_W'(k + 1);
          end
        end
        hard_latch = 1'b1;
        sticky_a = sticky_a | a;
        sticky_b = sticky_b | b;
      end
    end
    r.hard_fault_active = hard_latch;
    r.soft_fault_active = |soft_now;
    r.hard_mask_a = sticky_a;
    r.hard_mask_b = sticky_b;
    r.soft_mask = soft_now;
    r.first_fault_code = first_code;
    return r;
  endfunction

  task automatic report_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s expected %0h got %0h", $time, field, exp_v, act_v);
      end
    end
  endtask

  function automatic void queue_word(logic [DT_W-1:0] dt, logic [RAW_W-1:0] raw,
                                     logic [SOFT_W-1:0] soft_cond, logic [DH_W-1:0] dh);
    pending_words.push_back('{elapsed: dt, raw: raw, soft_cond: soft_cond, hard: dh});
  endfunction

  task automatic set_confirm(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] ticks);
    cfg_bus.index <= idx;
    cfg_bus.data <= ticks;
    cfg_bus.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    if (idx < NUM_CFG) confirm_ticks[idx[1:0]] = ticks;
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all(logic [CFG_W-1:0] leak, logic [CFG_W-1:0] drv,
                         logic [CFG_W-1:0] stall, logic [CFG_W-1:0] temp);
    set_confirm(CFG_IDX_W'(REG_LEAK), leak);
    set_confirm(CFG_IDX_W'(REG_DRIVER), drv);
    set_confirm(CFG_IDX_W'(REG_STALL), stall);
    set_confirm(CFG_IDX_W'(REG_TEMP), temp);
  endtask

  task automatic drain;
    while (pending_words.size() != 0 || in_bus.valid || status_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // lanes follow long and short high runs so debounce timers get to finish
  task automatic queue_random(int count);
    logic [DT_W-1:0]   dt;
    logic [RAW_W-1:0]  raw;
    logic [DH_W-1:0]   dh;
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        dt_mode = dt_mode_e'($urandom_range(0, 2));
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      for (int k = 0; k < NUM_LANES; k++) begin
        if (run_left[k] == 0) begin
          lane_raw[k] = !lane_raw[k];
          if (lane_raw[k] && $urandom_range(0, 5) == 0) begin
            run_left[k] = $urandom_range(200, 400);
          end else begin
            run_left[k] = $urandom_range(1, 12);
          end
        end
        run_left[k]--;
      end
      case (dt_mode)
        DT_LONG: begin
          dt = ($urandom_range(0, 3) == 0) ? DT_W'($urandom_range(50000, 65535)) : '1;
        end
        DT_SHORT: begin
          dt = DT_W'($urandom_range(1, 64));
        end
        default: begin
          dt = DT_W'($urandom_range(0, 65535));
        end
      endcase
      if ($urandom_range(0, 9) == 0) dt = '0;
      raw = ($urandom_range(0, 19) == 0) ? RAW_W'($urandom_range(0, 63)) : lane_raw;
      dh = '0;
      if ($urandom_range(0, 79) == 0) dh = DH_W'(1 << $urandom_range(0, DH_W - 1));
      if ($urandom_range(0, 199) == 0) dh = DH_W'($urandom_range(0, 63));
      queue_word(dt, raw, SOFT_W'($urandom_range(0, 31)), dh);
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) status_q.push_back(step_status(driven_word));
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          driven_word = next_word;
          in_bus.elapsed_ticks <= next_word.elapsed;
          in_bus.debounce_raw <= next_word.raw;
          in_bus.soft_conditions <= next_word.soft_cond;
          in_bus.direct_hard <= next_word.hard;
          in_bus.valid <= 1'b1;
          in_gap = steady_in ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (status_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with nothing expected", $time);
        end else begin
          automatic result_t exp_r = status_q.pop_front();
          report_field("hard_fault_active", 32'(exp_r.hard_fault_active),
                       32'(out_bus.hard_fault_active));
          report_field("soft_fault_active", 32'(exp_r.soft_fault_active),
                       32'(out_bus.soft_fault_active));
          report_field("hard_mask_a", 32'(exp_r.hard_mask_a), 32'(out_bus.hard_mask_a));
          report_field("hard_mask_b", 32'(exp_r.hard_mask_b), 32'(out_bus.hard_mask_b));
          report_field("soft_mask", 32'(exp_r.soft_mask), 32'(out_bus.soft_mask));
          report_field("first_fault_code", 32'(exp_r.first_fault_code),
                       32'(out_bus.first_fault_code));
        end
        out_stall = steady_out ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // stretches with and without idling on each side
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) steady_in = !steady_in;
    if ($urandom_range(0, 199) == 0) steady_out = !steady_out;
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.elapsed_ticks = '0;
    in_bus.debounce_raw = '0;
    in_bus.soft_conditions = '0;
    in_bus.direct_hard = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    for (int k = 0; k < NUM_CFG; k++) confirm_ticks[k] = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_timer[k] = '0;
      run_left[k] = 0;
    end
    hard_latch = 1'b0;
    sticky_a = '0;
    sticky_b = '0;
    soft_now = '0;
    first_code = CODE_NONE;
    lane_raw = '1;
    seg_left = 0;
    dt_mode = DT_ANY;
    steady_in = 1'b0;
    steady_out = 1'b0;
    idle_cycles = 0;
    mismatch_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: queries and soft conditions only
    queue_word('0, '1, '1, '1);
    queue_word(16'd1, '0, 5'b00010, '0);
    queue_word('1, '0, 5'b11101, '0);
    queue_word('0, '0, '0, '0);
    drain();

    set_all(24'd5, CONFIRM_MAX, 24'd100000, 24'd1);
    // several hard bits at once: the lowest active bit sets the first fault code
    queue_word(16'd3, 6'b100000, 5'b01000, 6'b110010);
    queue_word(16'd2, 6'b000001, '0, '0);
    queue_word('0, '0, '0, '0);
    queue_word(16'd2, 6'b000001, 5'b00001, '0);
    queue_word(16'd1, '0, '0, '0);
    queue_word(16'd4, 6'b000001, '0, '0);
    queue_word(16'd1, 6'b000001, 5'b10000, '0);
    queue_word('1, 6'b011110, 5'b10101, '0);
    queue_word('1, 6'b011000, '0, '0);
    queue_word(16'd7, '0, 5'b00100, 6'b001101);
    drain();

    set_all(CONFIRM_MAX, 24'd40000, CONFIRM_MAX, 24'd700000);
    set_confirm(IDX_SPARE, CFG_W'($urandom_range(0, 24'hFFFFFF)));
    set_confirm(IDX_TOP, CONFIRM_MAX);
    queue_random(350);
    drain();

    set_all('0, 24'd1, 24'd250000, CONFIRM_MAX);
    queue_random(350);
    drain();

    set_all(CFG_W'($urandom_range(0, 24'hFFFFFF)), CFG_W'($urandom_range(0, 24'hFFFFFF)),
            CFG_W'($urandom_range(0, 24'hFFFF)), CFG_W'($urandom_range(0, 24'hFFFFFF)));
    queue_random(350);
    drain();

    set_all(24'd1, '0, '0, 24'd65535);
    queue_random(375);
    drain();

    if (mismatch_count == 0 && status_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
